FILE: rtl/habc_pkg.sv
`default_nettype none

package habc_pkg;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_WARMUP_MS     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GAS_LIMIT     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SMOKE_LIMIT   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_BUZZER_ON_MS  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_BUZZER_OFF_MS = 3'd4;
   localparam int CsrDataWidth = 20;

   // Field widths.
   localparam int WarmupWidth = 20;
   localparam int LevelWidth  = 10;
   localparam int PhaseWidth  = 16;
   localparam int KindWidth   = 2;

   // Reset values of the configuration registers.
   localparam logic [WarmupWidth-1:0] WARMUP_MS_RESET     = 20'd20000;
   localparam logic [LevelWidth-1:0]  GAS_LIMIT_RESET     = 10'd400;
   localparam logic [LevelWidth-1:0]  SMOKE_LIMIT_RESET   = 10'd300;
   localparam logic [PhaseWidth-1:0]  BUZZER_ON_MS_RESET  = 16'd500;
   localparam logic [PhaseWidth-1:0]  BUZZER_OFF_MS_RESET = 16'd500;

   // Alarm kind codes.
   localparam logic [KindWidth-1:0] KIND_NONE  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_FIRE  = 2'd1;
   localparam logic [KindWidth-1:0] KIND_LPG   = 2'd2;
   localparam logic [KindWidth-1:0] KIND_SMOKE = 2'd3;

   typedef struct packed {
      logic [WarmupWidth-1:0] warmup_ms;
      logic [LevelWidth-1:0]  gas_limit;
      logic [LevelWidth-1:0]  smoke_limit;
      logic [PhaseWidth-1:0]  buzzer_on_ms;
      logic [PhaseWidth-1:0]  buzzer_off_ms;
   } cfg_type;

   typedef struct packed {
      logic                  flame_seen;
      logic [LevelWidth-1:0] lpg_level;
      logic [LevelWidth-1:0] smoke_level;
   } sample_type;

   typedef struct packed {
      logic                 buzzer_on;
      logic [KindWidth-1:0] alarm_kind;
      logic                 warming_up;
      logic                 alarm_started;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/habc_csr.sv
`default_nettype none

module habc_csr
   import habc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WARMUP_MS:     cfg_in.warmup_ms     = csr_wdata[WarmupWidth-1:0];
            CSR_GAS_LIMIT:     cfg_in.gas_limit     = csr_wdata[LevelWidth-1:0];
            CSR_SMOKE_LIMIT:   cfg_in.smoke_limit   = csr_wdata[LevelWidth-1:0];
            CSR_BUZZER_ON_MS:  cfg_in.buzzer_on_ms  = csr_wdata[PhaseWidth-1:0];
            CSR_BUZZER_OFF_MS: cfg_in.buzzer_off_ms = csr_wdata[PhaseWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warmup_ms     <= WARMUP_MS_RESET;
         cfg_ff.gas_limit     <= GAS_LIMIT_RESET;
         cfg_ff.smoke_limit   <= SMOKE_LIMIT_RESET;
         cfg_ff.buzzer_on_ms  <= BUZZER_ON_MS_RESET;
         cfg_ff.buzzer_off_ms <= BUZZER_OFF_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/habc_alarm.sv
`default_nettype none

module habc_alarm
   import habc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire sample_type sample,
   input  wire cfg_type    cfg,
   output result_type      result
);

   localparam logic [PhaseWidth-1:0] PhaseMax = {PhaseWidth{1'b1}};

   logic                   warming_ff,      warming_in;
   logic [WarmupWidth-1:0] warmup_count_ff, warmup_count_in;
   logic [KindWidth-1:0]   active_kind_ff,  active_kind_in;
   logic                   buzzer_ff,       buzzer_in;
   logic [PhaseWidth-1:0]  phase_ff,        phase_in;

   logic [KindWidth-1:0]  detected;
   logic                  in_warmup;
   logic                  changed;
   logic                  started;
   logic                  level;
   logic [PhaseWidth-1:0] phase;
   logic [PhaseWidth-1:0] limit;
   logic [PhaseWidth-1:0] elapsed;

   // Alarm selection by priority: fire, then LPG, then smoke.
   always_comb begin
      priority if (sample.flame_seen)                    detected = KIND_FIRE;
      else if (sample.lpg_level > cfg.gas_limit)         detected = KIND_LPG;
      else if (sample.smoke_level > cfg.smoke_limit)     detected = KIND_SMOKE;
      else                                               detected = KIND_NONE;
   end

   assign in_warmup = warming_ff && (warmup_count_ff < cfg.warmup_ms);
   assign changed   = (detected != active_kind_ff);
   assign started   = changed && (detected != KIND_NONE);

   // Buzzer level and phase after a possible restart, then the blink step.
   always_comb begin
      level   = changed ? (detected != KIND_NONE) : buzzer_ff;
      phase   = changed ? '0 : phase_ff;
      limit   = level ? cfg.buzzer_on_ms : cfg.buzzer_off_ms;
      elapsed = started ? '0 : ((phase == PhaseMax) ? PhaseMax : phase + 1'b1);

      warming_in      = warming_ff;
      warmup_count_in = warmup_count_ff;
      active_kind_in  = active_kind_ff;
      buzzer_in       = buzzer_ff;
      phase_in        = phase_ff;

      if (in_warmup) begin
         warmup_count_in = warmup_count_ff + 1'b1;
         result.buzzer_on     = 1'b0;
         result.alarm_kind    = KIND_NONE;
         result.warming_up    = 1'b1;
         result.alarm_started = 1'b0;
      end else begin
         warming_in     = 1'b0;
         active_kind_in = detected;
         buzzer_in      = level;
         phase_in       = phase;
         if (detected != KIND_NONE) begin
            if (elapsed >= limit) begin
               buzzer_in = !level;
               phase_in  = '0;
            end else begin
               phase_in = elapsed;
            end
         end
         result.buzzer_on     = buzzer_in;
         result.alarm_kind    = detected;
         result.warming_up    = 1'b0;
         result.alarm_started = started;
      end
   end

   // The state advances once per evaluated request.
   always_ff @(posedge clock) begin
      if (reset) begin
         warming_ff      <= 1'b1;
         warmup_count_ff <= '0;
         active_kind_ff  <= KIND_NONE;
         buzzer_ff       <= 1'b0;
         phase_ff        <= '0;
      end else if (step) begin
         warming_ff      <= warming_in;
         warmup_count_ff <= warmup_count_in;
         active_kind_ff  <= active_kind_in;
         buzzer_ff       <= buzzer_in;
         phase_ff        <= phase_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/hazard_alarm_buzzer_controller_core.sv
`default_nettype none

// Hazard alarm buzzer controller. Each request is one millisecond tick with the
// flame bit and the LPG and smoke samples; each produces exactly one response with
// the buzzer level, the active alarm kind, the warm-up flag and an alarm-start
// flag. A request is held in an input register and is evaluated into an output
// register once that slot is free or its response is being taken; one request
// is taken every cycle while responses drain. The evaluation stage with its
// alarm state registers, updated once per evaluated request, sets that rate.
// Configuration registers are written through csr_we/csr_index/csr_wdata and
// must only be changed while no request is in flight.

module hazard_alarm_buzzer_controller_core
   import habc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_flame_seen,
   input  wire logic [LevelWidth-1:0]    req_lpg_level,
   input  wire logic [LevelWidth-1:0]    req_smoke_level,

   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_buzzer_on,
   output logic [KindWidth-1:0]          rsp_alarm_kind,
   output logic                          rsp_warming_up,
   output logic                          rsp_alarm_started,

   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type    cfg;
   sample_type sample_ff;
   logic       in_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   habc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The held request moves into the output register when that slot is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   habc_alarm u_alarm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sample (sample_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff.flame_seen  <= req_flame_seen;
         sample_ff.lpg_level   <= req_lpg_level;
         sample_ff.smoke_level <= req_smoke_level;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_buzzer_on     = rsp_ff.buzzer_on;
   assign rsp_alarm_kind    = rsp_ff.alarm_kind;
   assign rsp_warming_up    = rsp_ff.warming_up;
   assign rsp_alarm_started = rsp_ff.alarm_started;

endmodule

`default_nettype wire

FILE: rtl/habc_checker.sv
`default_nettype none

module habc_checker
   import habc_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_buzzer_on,
   input wire logic [KindWidth-1:0]     rsp_alarm_kind,
   input wire logic                     rsp_warming_up,
   input wire logic                     rsp_alarm_started
);

   // A waiting request stays valid until it is taken.
   a_req_hold_valid: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before acceptance");

   // A stalled response stays valid.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_buzzer_on) && $stable(rsp_alarm_kind)
         && $stable(rsp_warming_up) && $stable(rsp_alarm_started))
      else $error("response payload changed while stalled");

   // Warm-up ticks raise nothing.
   a_warmup_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_warming_up |->
         !rsp_buzzer_on && (rsp_alarm_kind == KIND_NONE) && !rsp_alarm_started)
      else $error("alarm output during warm-up");

   // An alarm start names a real alarm, and no alarm means a silent buzzer.
   a_start_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_alarm_started || (rsp_alarm_kind == KIND_NONE)) |->
         (rsp_alarm_started != (rsp_alarm_kind == KIND_NONE))
         && ((rsp_alarm_kind != KIND_NONE) || !rsp_buzzer_on))
      else $error("alarm start or idle buzzer inconsistent with alarm kind");

endmodule

bind hazard_alarm_buzzer_controller_core habc_checker u_habc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_buzzer_on     (rsp_buzzer_on),
   .rsp_alarm_kind    (rsp_alarm_kind),
   .rsp_warming_up    (rsp_warming_up),
   .rsp_alarm_started (rsp_alarm_started)
);

`default_nettype wire
